// ===== rtl/core/ims_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ims_pkg
// Types and constants for the IRC message field splitter: phase codes,
// byte roles, error codes and the parse state and result records.
// ----------------------------------------------------------------------------
package ims_pkg;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Highest number of parameters a message may carry.
  localparam logic [3:0] PARAM_LIMIT = 4'd15;

  typedef enum logic [6:0] {
    PH_START       = 7'b0000001,
    PH_PREFIX      = 7'b0000010,
    PH_CMD_START   = 7'b0000100,
    PH_CMD         = 7'b0001000,
    PH_PARAM_START = 7'b0010000,
    PH_MIDDLE      = 7'b0100000,
    PH_TRAILING    = 7'b1000000
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_DELIM    = 3'd0,
    ROLE_PREFIX   = 3'd1,
    ROLE_CMD      = 3'd2,
    ROLE_MIDDLE   = 3'd3,
    ROLE_TRAILING = 3'd4,
    ROLE_IGNORED  = 3'd5
  } role_t;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_EMPTY_PREFIX = 3'd1,
    ERR_NO_CMD       = 3'd2,
    ERR_EMPTY_CMD    = 3'd3,
    ERR_TOO_MANY     = 3'd4,
    ERR_EMPTY_PARAM  = 3'd5
  } err_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] params_seen;
    err_t       err;
    logic       field_empty;
  } parse_state_t;

  typedef struct packed {
    role_t      role;
    logic [3:0] idx;
    err_t       err;
    logic       done;
    logic       ok;
    logic [3:0] count;
  } result_t;

  localparam parse_state_t STATE_RESET = '{
    phase:       PH_START,
    params_seen: 4'd0,
    err:         ERR_NONE,
    field_empty: 1'b1
  };

endpackage

// ===== rtl/core/irc_message_field_splitter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_message_field_splitter_unit
// Tags each byte of an IRC message with its role, latches the first parse
// error and reports parameter count and status on the final byte.
//
//   Channel  Handshake           Beat contents
//   input    in_valid/in_ready   data_byte, end_of_message
//   output   out_valid/out_ready byte_role, param_index, error_code,
//                                message_done, message_ok, param_count
//
// Each beat is held in the input register and is then classified into the
// result register, from which its result is offered. One beat per cycle is
// sustained while the output is not stalled; the phase update is a single
// short step. Reset empties both registers and returns the parser to message
// start. A stall on the output backs up through the input register; the input
// keeps taking beats as long as either register has room.
// ----------------------------------------------------------------------------
module irc_message_field_splitter_unit
  import ims_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] byte_role,
  output logic [3:0] param_index,
  output logic [2:0] error_code,
  output logic       message_done,
  output logic       message_ok,
  output logic [3:0] param_count
);

  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         s1_last;
  logic         s1_adv;
  parse_state_t state;
  parse_state_t state_next;
  result_t      res_next;
  result_t      res;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= data_byte;
      s1_last <= end_of_message;
    end
  end

  ims_classify u_classify (
    .data_byte  (s1_byte),
    .last       (s1_last),
    .cur        (state),
    .state_next (state_next),
    .res        (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (s1_adv) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res <= res_next;
    end
  end

  assign byte_role    = res.role;
  assign param_index  = res.idx;
  assign error_code   = res.err;
  assign message_done = res.done;
  assign message_ok   = res.ok;
  assign param_count  = res.count;

  // After the final byte of a message is classified the parser is at start.
  a_restart_after_last : assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_last) |=> (state == STATE_RESET))
    else $error("parser not restarted after final byte");

  // A good-message flag only comes with the final byte and no error.
  a_ok_consistent : assert property (@(posedge clk) disable iff (rst)
    (out_valid && message_ok) |-> (message_done && error_code == ERR_NONE))
    else $error("message_ok without final byte or with error");

  // Once an error is latched, every byte of the message is ignored.
  a_error_ignores : assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_code != ERR_NONE) |->
      (byte_role == ROLE_IGNORED && param_index == 4'd0))
    else $error("byte classified after error");

  // Parameter count is reported on the final byte only.
  a_count_on_last : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !message_done) |-> (param_count == 4'd0 && !message_ok))
    else $error("status reported before final byte");

endmodule

// ===== rtl/core/ims_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ims_classify
// Combinational phase logic: classifies one byte against the current parse
// state and produces the result record and the next parse state.
// ----------------------------------------------------------------------------
module ims_classify
  import ims_pkg::*;
(
  input  logic [7:0]   data_byte,
  input  logic         last,
  input  parse_state_t cur,
  output parse_state_t state_next,
  output result_t      res
);

  parse_state_t nxt;
  role_t        role;
  logic [3:0]   idx;
  err_t         err_new;
  logic         is_space;
  logic         is_colon;

  assign is_space = (data_byte == CH_SPACE);
  assign is_colon = (data_byte == CH_COLON);

  always_comb begin
    nxt     = cur;
    role    = ROLE_IGNORED;
    idx     = 4'd0;
    err_new = ERR_NONE;
    if (cur.err == ERR_NONE) begin
      unique case (cur.phase)
        PH_PREFIX: begin
          if (is_space) begin
            if (cur.field_empty) begin
              err_new = ERR_EMPTY_PREFIX;
            end else begin
              role      = ROLE_DELIM;
              nxt.phase = PH_CMD_START;
              if (last) err_new = ERR_EMPTY_CMD;
            end
          end else begin
            role            = ROLE_PREFIX;
            nxt.field_empty = 1'b0;
            if (last) err_new = ERR_NO_CMD;
          end
        end
        PH_CMD_START: begin
          if (is_space) begin
            err_new = ERR_EMPTY_CMD;
          end else begin
            role      = ROLE_CMD;
            nxt.phase = PH_CMD;
          end
        end
        PH_CMD, PH_MIDDLE: begin
          if (is_space) begin
            // The limit check wins over the empty-parameter check.
            if (cur.params_seen >= PARAM_LIMIT) begin
              err_new = ERR_TOO_MANY;
            end else begin
              role      = ROLE_DELIM;
              nxt.phase = PH_PARAM_START;
              if (last) err_new = ERR_EMPTY_PARAM;
            end
          end else if (cur.phase == PH_CMD) begin
            role = ROLE_CMD;
          end else begin
            role = ROLE_MIDDLE;
            idx  = cur.params_seen - 4'd1;
          end
        end
        PH_PARAM_START: begin
          if (is_space) begin
            err_new = ERR_EMPTY_PARAM;
          end else if (is_colon) begin
            role            = ROLE_DELIM;
            nxt.params_seen = cur.params_seen + 4'd1;
            nxt.phase       = PH_TRAILING;
          end else begin
            role            = ROLE_MIDDLE;
            idx             = cur.params_seen;
            nxt.params_seen = cur.params_seen + 4'd1;
            nxt.phase       = PH_MIDDLE;
          end
        end
        PH_TRAILING: begin
          role = ROLE_TRAILING;
          idx  = cur.params_seen - 4'd1;
        end
        default: begin
          // Message start; codes outside the phase set land here as well.
          if (is_colon) begin
            role            = ROLE_DELIM;
            nxt.field_empty = 1'b1;
            nxt.phase       = PH_PREFIX;
            if (last) err_new = ERR_EMPTY_PREFIX;
          end else if (is_space) begin
            err_new = ERR_EMPTY_CMD;
          end else begin
            role      = ROLE_CMD;
            nxt.phase = PH_CMD;
          end
        end
      endcase
    end
    if (err_new != ERR_NONE) begin
      nxt.err = err_new;
      role    = ROLE_IGNORED;
      idx     = 4'd0;
    end

    res.role  = role;
    res.idx   = idx;
    res.err   = nxt.err;
    res.done  = last;
    res.ok    = last && (nxt.err == ERR_NONE);
    res.count = last ? nxt.params_seen : 4'd0;

    // The final byte of a message always returns the parser to its start.
    state_next = last ? STATE_RESET : nxt;
  end

endmodule

// ===== sim/irc_message_field_splitter_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_message_field_splitter_unit_tb
// Drives IRC message bytes into the field splitter through a queue-fed driver
// and checks every output beat field by field against a byte classifier kept
// in the bench. Directed messages cover every error but too many parameters,
// then random messages run under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module irc_message_field_splitter_unit_tb;
  import ims_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_BEATS = 150;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } msg_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'd0;
  logic       end_of_message = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] byte_role;
  logic [3:0] param_index;
  logic [2:0] error_code;
  logic       message_done;
  logic       message_ok;
  logic [3:0] param_count;

  // Parser state as the bench sees it.
  phase_t     cur_phase;
  logic [3:0] params_found;
  err_t       first_error;
  logic       field_empty;

  msg_byte_t  pending_bytes[$];
  result_t    expected_tags[$];
  logic [7:0] msg_buf[$];

  int  error_count = 0;
  int  tagged_beats = 0;
  int  cycle_count = 0;
  int  idle_mode = 0;
  bit  in_beat = 1'b0;
  bit  sender_hold = 1'b0;
  bit  hold_off = 1'b0;

  irc_message_field_splitter_unit uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .byte_role      (byte_role),
    .param_index    (param_index),
    .error_code     (error_code),
    .message_done   (message_done),
    .message_ok     (message_ok),
    .param_count    (param_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function void clear_parser();
    cur_phase    = PH_START;
    params_found = 4'd0;
    first_error  = ERR_NONE;
    field_empty  = 1'b1;
  endfunction

  function automatic result_t classify_byte(input logic [7:0] b, input logic last);
    result_t r;
    err_t    e;
    r.role = ROLE_IGNORED;
    r.idx  = 4'd0;
    e      = ERR_NONE;
    if (first_error == ERR_NONE) begin
      case (cur_phase)
        PH_PREFIX: begin
          if (b == CH_SPACE) begin
            if (field_empty) begin
              e = ERR_EMPTY_PREFIX;
            end else begin
              r.role    = ROLE_DELIM;
              cur_phase = PH_CMD_START;
              if (last) e = ERR_EMPTY_CMD;
            end
          end else begin
            r.role      = ROLE_PREFIX;
            field_empty = 1'b0;
            if (last) e = ERR_NO_CMD;
          end
        end
        PH_CMD_START: begin
          if (b == CH_SPACE) begin
            e = ERR_EMPTY_CMD;
          end else begin
            r.role    = ROLE_CMD;
            cur_phase = PH_CMD;
          end
        end
        PH_CMD, PH_MIDDLE: begin
          // The parameter limit is checked before the empty-parameter case.
          if (b == CH_SPACE) begin
            if (params_found >= PARAM_LIMIT) begin
              e = ERR_TOO_MANY;
            end else begin
              r.role    = ROLE_DELIM;
              cur_phase = PH_PARAM_START;
              if (last) e = ERR_EMPTY_PARAM;
            end
          end else if (cur_phase == PH_CMD) begin
            r.role = ROLE_CMD;
          end else begin
            r.role = ROLE_MIDDLE;
            r.idx  = params_found - 4'd1;
          end
        end
        PH_PARAM_START: begin
          if (b == CH_SPACE) begin
            e = ERR_EMPTY_PARAM;
          end else if (b == CH_COLON) begin
            r.role       = ROLE_DELIM;
            params_found = params_found + 4'd1;
            cur_phase    = PH_TRAILING;
          end else begin
            r.role       = ROLE_MIDDLE;
            r.idx        = params_found;
            params_found = params_found + 4'd1;
            cur_phase    = PH_MIDDLE;
          end
        end
        PH_TRAILING: begin
          r.role = ROLE_TRAILING;
          r.idx  = params_found - 4'd1;
        end
        default: begin
          if (b == CH_COLON) begin
            r.role      = ROLE_DELIM;
            field_empty = 1'b1;
            cur_phase   = PH_PREFIX;
            if (last) e = ERR_EMPTY_PREFIX;
          end else if (b == CH_SPACE) begin
            e = ERR_EMPTY_CMD;
          end else begin
            r.role    = ROLE_CMD;
            cur_phase = PH_CMD;
          end
        end
      endcase
      if (e != ERR_NONE) begin
        first_error = e;
        r.role      = ROLE_IGNORED;
        r.idx       = 4'd0;
      end
    end
    r.err   = first_error;
    r.done  = last;
    r.ok    = last && (first_error == ERR_NONE);
    r.count = last ? params_found : 4'd0;
    if (last) clear_parser();
    return r;
  endfunction

  function void add_char(input logic [7:0] b);
    msg_buf.push_back(b);
  endfunction

  function void close_message();
    for (int i = 0; i < msg_buf.size(); i++) begin
      pending_bytes.push_back(msg_byte_t'{msg_buf[i], i == msg_buf.size() - 1});
    end
    msg_buf.delete();
  endfunction

  function automatic logic [7:0] word_char(input bit no_colon);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == CH_SPACE || (no_colon && b == CH_COLON));
    return b;
  endfunction

  // Mostly well-formed messages with random content; some are broken by a
  // cut, an extra space or a stray byte, and some are plain noise.
  function void random_message();
    int np;
    int pos;
    bit pfx;
    bit trail;
    msg_buf.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 2))
          0:       add_char(CH_SPACE);
          1:       add_char(CH_COLON);
          default: add_char(8'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      pfx = ($urandom_range(0, 3) == 0);
      if (pfx) begin
        add_char(CH_COLON);
        repeat ($urandom_range(1, 5)) add_char(word_char(1'b0));
        add_char(CH_SPACE);
      end
      add_char(word_char(!pfx));
      repeat ($urandom_range(0, 4)) add_char(word_char(1'b0));
      np    = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 16) : $urandom_range(0, 5);
      trail = (np != 0) && ($urandom_range(0, 2) == 0);
      for (int k = 0; k < np; k++) begin
        add_char(CH_SPACE);
        if (trail && k == np - 1) begin
          add_char(CH_COLON);
          repeat ($urandom_range(0, 8)) add_char(8'($urandom_range(0, 255)));
        end else begin
          add_char(word_char(1'b1));
          repeat ($urandom_range(0, 3)) add_char(word_char(1'b0));
        end
      end
      if ($urandom_range(0, 4) == 0) begin
        pos = $urandom_range(0, msg_buf.size() - 1);
        case ($urandom_range(0, 2))
          0:       msg_buf = msg_buf[0:pos];
          1:       msg_buf.insert(pos, CH_SPACE);
          default: msg_buf[pos] = 8'($urandom_range(0, 255));
        endcase
      end
    end
    close_message();
  endfunction

  function bit draw_idle();
    case (idle_mode)
      1, 2:    return $urandom_range(0, 99) < 79;
      3:       return $urandom_range(0, 99) < 29;
      default: return 1'b0;
    endcase
  endfunction

  task automatic run_phase(input int mode);
    int goal;
    idle_mode = mode;
    goal = tagged_beats + PHASE_BEATS;
    while (tagged_beats < goal) begin
      if (pending_bytes.size() < 40) random_message();
      else @(posedge clk);
    end
  endtask

  task automatic drain_results();
    sender_hold = 1'b1;
    while (in_valid || expected_tags.size() != 0) @(posedge clk);
    sender_hold = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Driver: a new beat is offered only once the previous one was taken.
  always @(negedge clk) begin : drive_bytes
    msg_byte_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beat) begin
      if (pending_bytes.size() != 0 && !sender_hold &&
          !((idle_mode == 1 || idle_mode == 3) && draw_idle())) begin
        nxt = pending_bytes.pop_front();
        in_valid       <= 1'b1;
        data_byte      <= nxt.b;
        end_of_message <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_off && !((idle_mode == 2 || idle_mode == 3) && draw_idle());
    end
  end

  // Monitor: predicts on every accepted input beat and checks output beats.
  always @(posedge clk) begin : watch_beats
    result_t want;
    if (rst) begin
      clear_parser();
      in_beat = 1'b0;
    end else begin
      in_beat = in_valid && in_ready;
      if (in_beat) expected_tags.push_back(classify_byte(data_byte, end_of_message));
      if (out_valid && out_ready) begin
        if (expected_tags.size() == 0) begin
          $error("unexpected output beat: byte_role %0d", byte_role);
          error_count++;
        end else begin
          want = expected_tags.pop_front();
          check_field("byte_role", 4'(want.role), 4'(byte_role));
          check_field("param_index", want.idx, param_index);
          check_field("error_code", 4'(want.err), 4'(error_code));
          check_field("message_done", 4'(want.done), 4'(message_done));
          check_field("message_ok", 4'(want.ok), 4'(message_ok));
          check_field("param_count", want.count, param_count);
        end
        if (byte_role != ROLE_IGNORED) tagged_beats++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Lone colon, and a colon followed by a space: empty prefix.
    add_char(CH_COLON);
    close_message();
    add_char(CH_COLON); add_char(CH_SPACE);
    close_message();
    // Message ends inside the prefix, then right after it.
    add_char(CH_COLON); add_char("p");
    close_message();
    add_char(CH_COLON); add_char("p"); add_char(CH_SPACE);
    close_message();
    // Leading space: empty command.
    add_char(CH_SPACE);
    close_message();
    // Ends on a separating space, then an empty trailing parameter.
    add_char("C"); add_char(CH_SPACE);
    close_message();
    add_char("C"); add_char(CH_SPACE); add_char(CH_COLON);
    close_message();
    // Zero byte as the command and an all-ones parameter byte.
    add_char(8'h00); add_char(CH_SPACE); add_char(8'hFF);
    close_message();
    // Double space, with a byte after the error that must be ignored.
    add_char("C"); add_char(CH_SPACE); add_char(CH_SPACE); add_char("x");
    close_message();
    drain_results();

    // Long receiver hold-off while the sender keeps offering beats.
    while (pending_bytes.size() < 30) random_message();
    fork
      begin
        hold_off = 1'b1;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    run_phase(0);
    drain_results();
    run_phase(1);
    run_phase(2);
    drain_results();
    run_phase(3);

    idle_mode = 0;
    while (pending_bytes.size() != 0 || in_valid || expected_tags.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== irc_message_field_splitter_unit.f =====
rtl/core/ims_pkg.sv
rtl/core/ims_classify.sv
rtl/core/irc_message_field_splitter_unit.sv
sim/irc_message_field_splitter_unit_tb.sv
